// File: rtl/box_plane_side_test_defines.svh
// ----------------------------------------------------------------------------
// box_plane_side_test_defines.svh
// Assertion macros for the box/plane side classifier. They are empty in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BOX_PLANE_SIDE_TEST_DEFINES_SVH
`define BOX_PLANE_SIDE_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle or implication property, clocked on clk, off during reset
`define BPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("box_plane_side_test: assertion failed");
// antecedent this cycle, consequent next cycle
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box_plane_side_test: assertion failed");
`else
`define BPS_ASSERT(lbl, prop)
`define BPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Widths, codes and stage payload types of the box/plane side classifier.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int CoordW = 24;   // center, signed Q16.8
	localparam int HalfW  = 23;   // half extent, unsigned Q15.8
	localparam int NormW  = 16;   // normal / axis component, signed Q1.15
	localparam int OffW   = 32;   // plane constant
	localparam int AxisW  = 48;   // three packed axis components
	localparam int CornW  = 25;   // center +/- half
	localparam int ProdAW = 32;   // normal * axis component
	localparam int DotAW  = 32;   // |normal . axis|, at most 3 * 2^30
	localparam int ProdCW = 41;   // normal * corner component
	localparam int SumCW  = 43;   // normal . corner
	localparam int RadPW  = 55;   // half * |normal . axis|
	localparam int RadW   = 57;   // projected radius
	localparam int WideW  = 64;   // final compares
	localparam int KShift = 15;   // Q1.15 normal scale
	localparam int CfgIdxW = 8;
	localparam int CfgDatW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_NORMAL_X     = 8'd0,
		REG_NORMAL_Y     = 8'd1,
		REG_NORMAL_Z     = 8'd2,
		REG_PLANE_OFFSET = 8'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIDE_OVERLAP = 2'd0,
		SIDE_POS     = 2'd1,
		SIDE_NEG     = 2'd2
	} side_t;

	typedef struct packed {
		logic signed [NormW-1:0] nx;
		logic signed [NormW-1:0] ny;
		logic signed [NormW-1:0] nz;
		logic signed [OffW-1:0]  offset;
	} plane_t;

	// after corner select and axis products
	typedef struct packed {
		logic                              aligned;
		logic [2:0][CornW-1:0]             near;   // center when oriented
		logic [2:0][CornW-1:0]             far;
		logic [2:0][HalfW-1:0]             half;
		logic [2:0][2:0][ProdAW-1:0]       pax;    // [axis][component]
	} s1_t;

	// after corner products and axis dot magnitudes
	typedef struct packed {
		logic                    aligned;
		logic [2:0][ProdCW-1:0]  pn;
		logic [2:0][ProdCW-1:0]  pf;
		logic [2:0][DotAW-1:0]   adot;
		logic [2:0][HalfW-1:0]   half;
	} s2_t;

	// after corner dot sums and radius terms
	typedef struct packed {
		logic                    aligned;
		logic [SumCW-1:0]        dn;
		logic [SumCW-1:0]        df;
		logic [2:0][RadPW-1:0]   rp;
	} s3_t;

endpackage

// File: rtl/bps_corner.sv
// ----------------------------------------------------------------------------
// bps_corner
// Stage 1: near/far corner select per axis and normal * axis products.
// ----------------------------------------------------------------------------
module bps_corner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  bps_pkg::plane_t               plane,
	input  logic                          aligned,
	input  logic signed [bps_pkg::CoordW-1:0] center_x,
	input  logic signed [bps_pkg::CoordW-1:0] center_y,
	input  logic signed [bps_pkg::CoordW-1:0] center_z,
	input  logic [bps_pkg::HalfW-1:0]     half_x,
	input  logic [bps_pkg::HalfW-1:0]     half_y,
	input  logic [bps_pkg::HalfW-1:0]     half_z,
	input  logic [bps_pkg::AxisW-1:0]     axis_a,
	input  logic [bps_pkg::AxisW-1:0]     axis_b,
	input  logic [bps_pkg::AxisW-1:0]     axis_c,
	output logic                          valid_s1,
	output bps_pkg::s1_t                  data_s1
);

	function automatic logic signed [bps_pkg::ProdAW-1:0] mul_nn(
		logic signed [bps_pkg::NormW-1:0] a,
		logic signed [bps_pkg::NormW-1:0] b
	);
		logic signed [bps_pkg::ProdAW-1:0] ax;
		logic signed [bps_pkg::ProdAW-1:0] bx;
		ax = a;
		bx = b;
		return ax * bx;
	endfunction

	logic signed [bps_pkg::NormW-1:0] nrm [3];
	logic signed [bps_pkg::CornW-1:0] ctr [3];
	logic signed [bps_pkg::CornW-1:0] hlf [3];
	logic [bps_pkg::AxisW-1:0]        axs [3];
	bps_pkg::s1_t                     d;

	assign nrm[0] = plane.nx;
	assign nrm[1] = plane.ny;
	assign nrm[2] = plane.nz;
	assign ctr[0] = center_x;   // sign extends
	assign ctr[1] = center_y;
	assign ctr[2] = center_z;
	assign hlf[0] = {2'b00, half_x};
	assign hlf[1] = {2'b00, half_y};
	assign hlf[2] = {2'b00, half_z};
	assign axs[0] = axis_a;
	assign axs[1] = axis_b;
	assign axs[2] = axis_c;

	always_comb begin
		d.aligned = aligned;
		d.half    = {half_z, half_y, half_x};
		for (int i = 0; i < 3; i++) begin
			if (!aligned) begin
				d.near[i] = ctr[i];
				d.far[i]  = ctr[i];
			end else if (nrm[i][bps_pkg::NormW-1]) begin
				d.near[i] = ctr[i] + hlf[i];
				d.far[i]  = ctr[i] - hlf[i];
			end else begin
				d.near[i] = ctr[i] - hlf[i];
				d.far[i]  = ctr[i] + hlf[i];
			end
			for (int j = 0; j < 3; j++) begin
				d.pax[j][i] = mul_nn(nrm[i],
					$signed(axs[j][bps_pkg::NormW*i +: bps_pkg::NormW]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= d;
		end
	end

endmodule

// File: rtl/bps_dot.sv
// ----------------------------------------------------------------------------
// bps_dot
// Stage 2: normal * corner products and |normal . axis| per box axis.
// ----------------------------------------------------------------------------
module bps_dot (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  bps_pkg::plane_t plane,
	input  logic            valid_s1,
	input  bps_pkg::s1_t    data_s1,
	output logic            valid_s2,
	output bps_pkg::s2_t    data_s2
);

	function automatic logic signed [bps_pkg::ProdCW-1:0] mul_nc(
		logic signed [bps_pkg::NormW-1:0] a,
		logic signed [bps_pkg::CornW-1:0] b
	);
		logic signed [bps_pkg::ProdCW-1:0] ax;
		logic signed [bps_pkg::ProdCW-1:0] bx;
		ax = a;
		bx = b;
		return ax * bx;
	endfunction

	localparam int SumAW = bps_pkg::ProdAW + 2;

	logic signed [bps_pkg::NormW-1:0] nrm [3];
	logic signed [SumAW-1:0]          dsum [3];
	logic signed [SumAW-1:0]          dabs [3];
	bps_pkg::s2_t                     d;

	assign nrm[0] = plane.nx;
	assign nrm[1] = plane.ny;
	assign nrm[2] = plane.nz;

	always_comb begin
		d.aligned = data_s1.aligned;
		d.half    = data_s1.half;
		for (int i = 0; i < 3; i++) begin
			d.pn[i] = mul_nc(nrm[i], $signed(data_s1.near[i]));
			d.pf[i] = mul_nc(nrm[i], $signed(data_s1.far[i]));
		end
		for (int j = 0; j < 3; j++) begin
			dsum[j] = SumAW'($signed(data_s1.pax[j][0]))
				+ SumAW'($signed(data_s1.pax[j][1]))
				+ SumAW'($signed(data_s1.pax[j][2]));
			dabs[j] = dsum[j][SumAW-1] ? -dsum[j] : dsum[j];
			// magnitude is at most 3 * 2^30, so it fits the narrower field
			d.adot[j] = dabs[j][bps_pkg::DotAW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= d;
		end
	end

endmodule

// File: rtl/bps_radius.sv
// ----------------------------------------------------------------------------
// bps_radius
// Stage 3: corner dot sums and half * |normal . axis| radius terms.
// ----------------------------------------------------------------------------
module bps_radius (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         valid_s2,
	input  bps_pkg::s2_t data_s2,
	output logic         valid_s3,
	output bps_pkg::s3_t data_s3
);

	function automatic logic [bps_pkg::RadPW-1:0] mul_hr(
		logic [bps_pkg::HalfW-1:0] a,
		logic [bps_pkg::DotAW-1:0] b
	);
		logic [bps_pkg::RadPW-1:0] ax;
		logic [bps_pkg::RadPW-1:0] bx;
		ax = bps_pkg::RadPW'(a);
		bx = bps_pkg::RadPW'(b);
		return ax * bx;
	endfunction

	logic signed [bps_pkg::SumCW-1:0] dn;
	logic signed [bps_pkg::SumCW-1:0] df;
	bps_pkg::s3_t                     d;

	always_comb begin
		dn = bps_pkg::SumCW'($signed(data_s2.pn[0]))
			+ bps_pkg::SumCW'($signed(data_s2.pn[1]))
			+ bps_pkg::SumCW'($signed(data_s2.pn[2]));
		df = bps_pkg::SumCW'($signed(data_s2.pf[0]))
			+ bps_pkg::SumCW'($signed(data_s2.pf[1]))
			+ bps_pkg::SumCW'($signed(data_s2.pf[2]));
		d.aligned = data_s2.aligned;
		d.dn      = dn;
		d.df      = df;
		for (int j = 0; j < 3; j++) begin
			d.rp[j] = mul_hr(data_s2.half[j], data_s2.adot[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= d;
		end
	end

endmodule

// File: rtl/box_plane_side_test.sv
// ----------------------------------------------------------------------------
// box_plane_side_test
// Classifies one box per beat against a plane n.p = c: positive side,
// negative side or overlap.
//
// Channels: input beats (in_valid/in_ready) carry one box, aligned selects
// the two-corner test, otherwise the oriented test using axis_a/b/c. Output
// beats (out_valid/out_ready) carry side and hit. The plane is set through
// the cfg_valid/cfg_index/cfg_data write port (always ready; unknown indexes
// are dropped), and must only be written while no box is in flight.
// Pipeline: stage 1 loads at the accepting edge, and the box then passes
// through four register stages in order (corner/axis products, corner
// products and axis dot magnitudes, dot sums and radius terms, final compare
// into the output register); out_valid rises once it is in the last one.
// Throughput: one box per cycle while the output is not stalled; in_ready is
// high whenever the output register is empty or being taken.
// Stall: with out_valid high and out_ready low the whole pipeline holds,
// in_ready drops, and nothing is lost or repeated.
// Reset: pipeline emptied, normal = (0, 0, 32767), plane constant 0.
// ----------------------------------------------------------------------------
`include "box_plane_side_test_defines.svh"

module box_plane_side_test (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bps_pkg::CfgIdxW-1:0]           cfg_index,
	input  logic [bps_pkg::CfgDatW-1:0]           cfg_data,
	// box input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  aligned,
	input  logic signed [bps_pkg::CoordW-1:0]     center_x,
	input  logic signed [bps_pkg::CoordW-1:0]     center_y,
	input  logic signed [bps_pkg::CoordW-1:0]     center_z,
	input  logic [bps_pkg::HalfW-1:0]             half_x,
	input  logic [bps_pkg::HalfW-1:0]             half_y,
	input  logic [bps_pkg::HalfW-1:0]             half_z,
	input  logic [bps_pkg::AxisW-1:0]             axis_a,
	input  logic [bps_pkg::AxisW-1:0]             axis_b,
	input  logic [bps_pkg::AxisW-1:0]             axis_c,
	// result output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            side,
	output logic                                  hit
);

	// plane registers
	bps_pkg::plane_t plane_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.nx     <= '0;
			plane_q.ny     <= '0;
			plane_q.nz     <= 16'sh7fff;
			plane_q.offset <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bps_pkg::reg_idx_t'(cfg_index))
				bps_pkg::REG_NORMAL_X:     plane_q.nx     <= cfg_data[bps_pkg::NormW-1:0];
				bps_pkg::REG_NORMAL_Y:     plane_q.ny     <= cfg_data[bps_pkg::NormW-1:0];
				bps_pkg::REG_NORMAL_Z:     plane_q.nz     <= cfg_data[bps_pkg::NormW-1:0];
				bps_pkg::REG_PLANE_OFFSET: plane_q.offset <= cfg_data[bps_pkg::OffW-1:0];
				default: ;
			endcase
		end
	end

	// global advance: every stage moves when the output slot frees up
	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	bps_pkg::s1_t data_s1;
	bps_pkg::s2_t data_s2;
	bps_pkg::s3_t data_s3;
	bps_pkg::side_t side_s4;

	assign en       = !valid_s4 || out_ready;
	assign in_ready = en;

	bps_corner u_corner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.plane    (plane_q),
		.aligned  (aligned),
		.center_x (center_x),
		.center_y (center_y),
		.center_z (center_z),
		.half_x   (half_x),
		.half_y   (half_y),
		.half_z   (half_z),
		.axis_a   (axis_a),
		.axis_b   (axis_b),
		.axis_c   (axis_c),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	bps_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.plane    (plane_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	bps_radius u_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	// stage 4: radius sum and compares
	// k = c * 2^15 lines c up with the 23 fraction bits of n.p;
	// oriented distance is scaled again by 2^15 to meet the 38 fraction bits of the radius.
	logic [bps_pkg::RadW-1:0]          rad;
	logic signed [bps_pkg::WideW-1:0]  kx;
	logic signed [bps_pkg::WideW-1:0]  dnx;
	logic signed [bps_pkg::WideW-1:0]  dfx;
	logic signed [bps_pkg::WideW-1:0]  sdist;
	logic signed [bps_pkg::WideW-1:0]  radx;
	bps_pkg::side_t                    side_d;

	always_comb begin
		rad = bps_pkg::RadW'(data_s3.rp[0]) + bps_pkg::RadW'(data_s3.rp[1])
			+ bps_pkg::RadW'(data_s3.rp[2]);
		radx  = $signed(bps_pkg::WideW'(rad));
		kx    = bps_pkg::WideW'(plane_q.offset) <<< bps_pkg::KShift;
		dnx   = bps_pkg::WideW'($signed(data_s3.dn));
		dfx   = bps_pkg::WideW'($signed(data_s3.df));
		sdist = (dnx - kx) <<< bps_pkg::KShift;
		if (data_s3.aligned) begin
			// strict tests; a tie is overlap
			priority if (dnx > kx) side_d = bps_pkg::SIDE_POS;
			else if (dfx < kx)     side_d = bps_pkg::SIDE_NEG;
			else                   side_d = bps_pkg::SIDE_OVERLAP;
		end else begin
			// non-strict tests; positive wins when d = r = 0
			priority if (sdist >= radx) side_d = bps_pkg::SIDE_POS;
			else if (sdist <= -radx)    side_d = bps_pkg::SIDE_NEG;
			else                        side_d = bps_pkg::SIDE_OVERLAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_d;
		end
	end

	assign out_valid = valid_s4;
	assign side      = side_s4;
	assign hit       = (side_s4 == bps_pkg::SIDE_OVERLAP);

	// a held beat freezes stage 1 along with the rest
	`BPS_ASSERT_NEXT(a_s1_hold, valid_s1 && !en, valid_s1 && $stable(data_s1))
	// a beat in stage 3 reaches the output register when the pipe advances
	`BPS_ASSERT_NEXT(a_s3_advance, valid_s3 && en, valid_s4)
	// only defined side codes leave the block
	`BPS_ASSERT(a_side_code, out_valid |-> (side == bps_pkg::SIDE_OVERLAP || side == bps_pkg::SIDE_POS || side == bps_pkg::SIDE_NEG))

endmodule
